// File: rtl/core/mse_pkg.sv
// Shared types, opcodes and constants for the MIPS-subset execute block.
package mse_pkg;

    localparam int XLEN          = 32;
    localparam int IDX_W         = 5;
    localparam int PLEN_W        = 17;
    localparam int STAT_W        = 2;
    localparam int IMM_W         = 16;
    localparam int REG_COUNT_DEF = 32;
    localparam int DEC_DEPTH_DEF = 2;
    localparam int RES_DEPTH_DEF = 2;

    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_ADDI    = 6'd8;

    localparam logic [5:0] FN_SLL = 6'd0;
    localparam logic [5:0] FN_SRL = 6'd2;
    localparam logic [5:0] FN_SRA = 6'd3;
    localparam logic [5:0] FN_ADD = 6'd32;
    localparam logic [5:0] FN_AND = 6'd36;
    localparam logic [5:0] FN_OR  = 6'd37;
    localparam logic [5:0] FN_SLT = 6'd42;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_MORE = 2'd2;

    localparam logic REQ_EXEC = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [3:0] {
        K_READ, K_ADD, K_AND, K_OR, K_SLL, K_SRL, K_SRA, K_SLT,
        K_ADDI, K_BEQ, K_BNE, K_UNK
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] ra;
        logic [IDX_W-1:0] rb;
        logic [IDX_W-1:0] dest;
        logic [IDX_W-1:0] sa;
        logic [IMM_W-1:0] imm;
    } t_dec;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [XLEN-1:0]   next_pc;
        logic              wrote_reg;
        logic [IDX_W-1:0]  write_index;
        logic [XLEN-1:0]   write_value;
        logic              branch_taken;
        logic [XLEN-1:0]   read_value;
    } t_res;

    typedef struct packed {
        logic push;
        logic pop;
    } t_qctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qsts;

endpackage

// File: rtl/core/mips_subset_execute_step.sv
// Top level of the MIPS-subset execute block: front decode, op queue, back end.
//
// Input channel: a transaction is taken when push is high and full is low.
// req_type selects execute (instruction at the current pc) or a register read.
// Result channel: while empty is low the oldest result sits on the o_ ports;
// it leaves on an edge with pop high. One result per input transaction,
// in order.
// Configuration: i_cfg_we writes i_cfg_wdata into program_length; write only
// while no transaction is in flight.
// Path: decode queue, register read stage, then execute into the result queue.
// Throughput: one transaction per cycle unless the result queue is full; the
// register file is read in the read stage and written at execute, with a
// bypass from the retiring write.
// Reset (synchronous, active low) clears the pc, program_length, register
// valid bits (all registers read zero) and both queues.
// When pop stays low the result queue fills, execute stalls, the decode queue
// fills and full rises; nothing is dropped.
module mips_subset_execute_step #(
    parameter int REG_COUNT = mse_pkg::REG_COUNT_DEF,
    parameter int DEC_DEPTH = mse_pkg::DEC_DEPTH_DEF,
    parameter int RES_DEPTH = mse_pkg::RES_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mse_pkg::PLEN_W-1:0]   i_cfg_wdata,
    input  logic                         push,
    output logic                         full,
    input  logic                         i_req_type,
    input  logic [mse_pkg::XLEN-1:0]     i_instr_word,
    input  logic [mse_pkg::IDX_W-1:0]    i_reg_index,
    output logic                         empty,
    input  logic                         pop,
    output logic [mse_pkg::STAT_W-1:0]   o_status,
    output logic [mse_pkg::XLEN-1:0]     o_next_pc,
    output logic                         o_wrote_reg,
    output logic [mse_pkg::IDX_W-1:0]    o_write_index,
    output logic [mse_pkg::XLEN-1:0]     o_write_value,
    output logic                         o_branch_taken,
    output logic [mse_pkg::XLEN-1:0]     o_read_value
);
    import mse_pkg::*;

    t_qctl dq_ctl;
    t_qsts dq_sts;
    t_dec  dq_wdata;
    t_dec  dq_head;
    t_res  res;

    mse_front u_front (
        .i_push       (push),
        .i_req_type   (i_req_type),
        .i_instr_word (i_instr_word),
        .i_reg_index  (i_reg_index),
        .i_dq_sts     (dq_sts),
        .o_full       (full),
        .o_dq_push    (dq_ctl.push),
        .o_dq_data    (dq_wdata)
    );

    mse_queue #(
        .t_item (t_dec),
        .DEPTH  (DEC_DEPTH)
    ) u_dec_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dq_ctl),
        .i_wdata (dq_wdata),
        .o_sts   (dq_sts),
        .o_rdata (dq_head)
    );

    mse_back #(
        .REG_COUNT (REG_COUNT),
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_dq_sts    (dq_sts),
        .i_dq_head   (dq_head),
        .o_dq_pop    (dq_ctl.pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_status       = res.status;
    assign o_next_pc      = res.next_pc;
    assign o_wrote_reg    = res.wrote_reg;
    assign o_write_index  = res.write_index;
    assign o_write_value  = res.write_value;
    assign o_branch_taken = res.branch_taken;
    assign o_read_value   = res.read_value;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_no_write_r0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_wrote_reg |-> o_write_index != '0 && o_status == ST_DONE)
        else $error("bad register write report");

    a_refused_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_status != ST_DONE |-> !o_wrote_reg && !o_branch_taken
            && o_read_value == '0)
        else $error("refused or unknown transaction has side effects");

    a_branch_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_branch_taken |-> !o_wrote_reg)
        else $error("branch reported a register write");

endmodule

// File: rtl/core/mse_queue.sv
// Small synchronous FIFO of any item type.
module mse_queue #(
    parameter type t_item = logic,
    parameter int  DEPTH  = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mse_pkg::t_qctl i_ctl,
    input  t_item         i_wdata,
    output mse_pkg::t_qsts o_sts,
    output t_item         o_rdata
);
    import mse_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             full, empty, wr_ok, rd_ok;

    assign full  = (r_cnt == CNT_W'(DEPTH));
    assign empty = (r_cnt == '0);
    assign wr_ok = i_ctl.push && !full;
    assign rd_ok = i_ctl.pop && !empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (wr_ok) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (rd_ok) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (wr_ok && !rd_ok) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (rd_ok && !wr_ok) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    assign o_sts.full  = full;
    assign o_sts.empty = empty;
    assign o_rdata     = r_mem[r_rptr];

endmodule

// File: rtl/core/mse_front.sv
// Front end: accepts requests and decodes them into operation records.
module mse_front (
    input  logic                       i_push,
    input  logic                       i_req_type,
    input  logic [mse_pkg::XLEN-1:0]   i_instr_word,
    input  logic [mse_pkg::IDX_W-1:0]  i_reg_index,
    input  mse_pkg::t_qsts             i_dq_sts,
    output logic                       o_full,
    output logic                       o_dq_push,
    output mse_pkg::t_dec              o_dq_data
);
    import mse_pkg::*;

    logic [5:0] op;
    logic [5:0] fn;

    assign op = i_instr_word[31:26];
    assign fn = i_instr_word[5:0];

    always_comb begin
        o_dq_data.ra   = i_instr_word[25:21];
        o_dq_data.rb   = i_instr_word[20:16];
        o_dq_data.dest = i_instr_word[15:11];
        o_dq_data.sa   = i_instr_word[10:6];
        o_dq_data.imm  = i_instr_word[15:0];
        o_dq_data.kind = K_UNK;
        if (i_req_type == REQ_READ) begin
            o_dq_data.kind = K_READ;
            o_dq_data.ra   = i_reg_index;
        end else begin
            case (op)
                OP_SPECIAL: begin
                    case (fn)
                        FN_ADD:  o_dq_data.kind = K_ADD;
                        FN_AND:  o_dq_data.kind = K_AND;
                        FN_OR:   o_dq_data.kind = K_OR;
                        FN_SLL:  o_dq_data.kind = K_SLL;
                        FN_SRL:  o_dq_data.kind = K_SRL;
                        FN_SRA:  o_dq_data.kind = K_SRA;
                        FN_SLT:  o_dq_data.kind = K_SLT;
                        default: o_dq_data.kind = K_UNK;
                    endcase
                end
                OP_ADDI: begin
                    o_dq_data.kind = K_ADDI;
                    o_dq_data.dest = i_instr_word[20:16];
                end
                OP_BEQ:  o_dq_data.kind = K_BEQ;
                OP_BNE:  o_dq_data.kind = K_BNE;
                default: o_dq_data.kind = K_UNK;
            endcase
        end
    end

    assign o_full    = i_dq_sts.full;
    assign o_dq_push = i_push && !i_dq_sts.full;

endmodule

// File: rtl/core/mse_back.sv
// Back end: register read stage, execute/writeback, pc and result queue.
module mse_back #(
    parameter int REG_COUNT = mse_pkg::REG_COUNT_DEF,
    parameter int RES_DEPTH = mse_pkg::RES_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mse_pkg::PLEN_W-1:0]  i_cfg_wdata,
    input  mse_pkg::t_qsts              i_dq_sts,
    input  mse_pkg::t_dec               i_dq_head,
    output logic                        o_dq_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output mse_pkg::t_res               o_res
);
    import mse_pkg::*;

    logic [XLEN-1:0]      r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;
    logic [XLEN-1:0]      r_pc;
    logic [PLEN_W-1:0]    r_plen;

    logic                 r_s1_vld;
    t_dec                 r_s1;
    logic [XLEN-1:0]      r_rdat_a, r_rdat_b;
    logic                 r_vld_a, r_vld_b;
    logic                 r_byp_a, r_byp_b;
    logic [XLEN-1:0]      r_byp_val;

    t_qsts                rq_sts;
    t_qctl                rq_ctl;
    t_res                 res;
    logic                 fire, s1_load, do_write, past_end, wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [XLEN-1:0]      wr_val, opa, opb, imm_ext, pc_plus4, br_tgt;

    assign fire     = r_s1_vld && !rq_sts.full;
    assign s1_load  = !i_dq_sts.empty && (!r_s1_vld || fire);
    assign o_dq_pop = s1_load;

    assign opa = r_byp_a ? r_byp_val : (r_vld_a ? r_rdat_a : '0);
    assign opb = r_byp_b ? r_byp_val : (r_vld_b ? r_rdat_b : '0);

    assign imm_ext  = {{(XLEN - IMM_W){r_s1.imm[IMM_W-1]}}, r_s1.imm};
    assign pc_plus4 = r_pc + XLEN'(4);
    assign br_tgt   = pc_plus4 + {imm_ext[XLEN-3:0], 2'b00};
    assign past_end = (r_pc[XLEN-1:2] >= (XLEN-2)'(r_plen));

    always_comb begin
        res      = '0;
        res.status  = ST_DONE;
        res.next_pc = r_pc;
        do_write = 1'b0;
        wr_val   = '0;
        if (r_s1.kind == K_READ) begin
            res.read_value = opa;
        end else if (past_end) begin
            res.status = ST_NO_MORE;
        end else begin
            res.next_pc = pc_plus4;
            case (r_s1.kind)
                K_ADD: begin
                    do_write = 1'b1;
                    wr_val   = opa + opb;
                end
                K_AND: begin
                    do_write = 1'b1;
                    wr_val   = opa & opb;
                end
                K_OR: begin
                    do_write = 1'b1;
                    wr_val   = opa | opb;
                end
                K_SLL: begin
                    do_write = 1'b1;
                    wr_val   = opb << r_s1.sa;
                end
                K_SRL: begin
                    do_write = 1'b1;
                    wr_val   = opb >> r_s1.sa;
                end
                K_SRA: begin
                    do_write = 1'b1;
                    wr_val   = $signed(opb) >>> r_s1.sa;
                end
                K_SLT: begin
                    do_write = 1'b1;
                    wr_val   = XLEN'($signed(opa) < $signed(opb));
                end
                K_ADDI: begin
                    do_write = 1'b1;
                    wr_val   = opa + imm_ext;
                end
                K_BEQ, K_BNE: begin
                    if ((r_s1.kind == K_BEQ) == (opa == opb)) begin
                        res.branch_taken = 1'b1;
                        res.next_pc      = br_tgt;
                    end
                end
                default: res.status = ST_UNKNOWN;
            endcase
            if (do_write && (r_s1.dest != '0)) begin
                res.wrote_reg   = 1'b1;
                res.write_index = r_s1.dest;
                res.write_value = wr_val;
            end
        end
    end

    assign wr_en  = fire && res.wrote_reg;
    assign wr_idx = res.write_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_vld    <= '0;
            r_pc     <= '0;
            r_plen   <= '0;
        end else begin
            if (s1_load) begin
                r_s1_vld <= 1'b1;
            end else if (fire) begin
                r_s1_vld <= 1'b0;
            end
            if (wr_en) begin
                r_vld[wr_idx] <= 1'b1;
            end
            if (fire) begin
                r_pc <= res.next_pc;
            end
            if (i_cfg_we) begin
                r_plen <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= res.write_value;
        end
        if (s1_load) begin
            r_rdat_a <= r_mem[i_dq_head.ra];
            r_rdat_b <= r_mem[i_dq_head.rb];
        end
    end

    // operand bypass for a write retiring in the same cycle as the read
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1      <= i_dq_head;
            r_vld_a   <= r_vld[i_dq_head.ra];
            r_vld_b   <= r_vld[i_dq_head.rb];
            r_byp_a   <= wr_en && (wr_idx == i_dq_head.ra);
            r_byp_b   <= wr_en && (wr_idx == i_dq_head.rb);
            r_byp_val <= res.write_value;
        end
    end

    assign rq_ctl.push = fire;
    assign rq_ctl.pop  = i_pop;

    mse_queue #(
        .t_item (t_res),
        .DEPTH  (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rq_ctl),
        .i_wdata (res),
        .o_sts   (rq_sts),
        .o_rdata (o_res)
    );

    assign o_empty = rq_sts.empty;

endmodule
